@@ rtl/core/bwr_pkg.sv @@
package bwr_pkg;

    // window geometry
    localparam int SLOT_CNT    = 32;
    localparam int MAX_SAMPLES = 4096;
    localparam int SLOT_W      = $clog2(SLOT_CNT);
    localparam int POS_W       = $clog2(MAX_SAMPLES);
    localparam int LAG_W       = SLOT_W + 1;
    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 48;
    localparam int COUNT_W     = 13;
    localparam int DEPTH_W     = 6;
    localparam int RESULT_W    = 16;

    // configuration register indexes
    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_WINDOW_DEPTH = 1'b1;

    // per-sample command broadcast to every cell
    typedef struct packed {
        logic                       valid;
        logic                       clr;
        logic [SLOT_W-1:0]          head;
        logic [LAG_W-1:0]           held;
        logic [POS_W-1:0]           pos;
        logic signed [SAMPLE_W-1:0] sample;
    } t_cell_cmd;

    // drain control broadcast to every cell
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

@@ rtl/core/bwr_ram.sv @@
module bwr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single port, read-first
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

@@ rtl/core/bwr_cell.sv @@
module bwr_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [bwr_pkg::SLOT_W-1:0]      i_slot,
    input  bwr_pkg::t_cell_cmd              i_cmd,
    input  bwr_pkg::t_cell_ctl              i_ctl,
    input  logic signed [bwr_pkg::ACC_W-1:0] i_next_res,
    output logic signed [bwr_pkg::ACC_W-1:0] o_res
);
    import bwr_pkg::*;

    logic [SLOT_W-1:0]          lag_raw;
    logic [LAG_W-1:0]           lag;
    logic                       en;
    logic                       we;
    logic [SAMPLE_W-1:0]        rdata;
    logic                       r_v1, r_en1, r_clr1;
    logic signed [SAMPLE_W-1:0] r_s1;
    logic                       r_v2, r_en2, r_clr2;
    logic signed [2*SAMPLE_W-1:0] r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    r_res;

    // lag of the vector in this slot; zero wraps to a full window
    assign lag_raw = i_cmd.head - i_slot;
    assign lag     = (lag_raw == '0) ? LAG_W'(SLOT_CNT) : {1'b0, lag_raw};
    assign en      = (lag <= i_cmd.held);
    assign we      = i_cmd.valid && (i_cmd.head == i_slot);

    bwr_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (i_cmd.pos),
        .i_wdata (i_cmd.sample),
        .o_rdata (rdata)
    );

    // stages 1 and 2: stored sample comes out of the slot memory, then the product is registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.valid;
            r_v2 <= r_v1;
        end
        r_en1  <= en;
        r_clr1 <= i_cmd.clr;
        r_s1   <= i_cmd.sample;
        r_en2  <= r_en1;
        r_clr2 <= r_clr1;
        r_prod <= r_s1 * $signed(rdata);
    end

    // stage 3: accumulate, snapshot and ring shift for the drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.load) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= (r_clr2 ? ACC_W'(0) : r_acc)
                   + (r_en2 ? ACC_W'(r_prod) : ACC_W'(0));
        end
        if (i_ctl.load) begin
            r_res <= r_acc;
        end else if (i_ctl.shift) begin
            r_res <= i_next_res;
        end
    end

    assign o_res = r_res;

endmodule

@@ rtl/core/banded_window_r_squared.sv @@
// Banded sliding-window r squared. Samples enter one word per cycle while the
// sequencer is running; each of the 32 cells owns one ring slot (a 4096 x 16
// memory) and one 48-bit dot accumulator, so every sample is multiplied against
// all held vectors at once. When the last sample of a vector is taken, input
// stops: the 3-stage cell pipeline is flushed, then, if there are partners, the
// result ring is rotated to the oldest partner, then each result goes through
// abs, range check, 31 steps of the shared bit-serial divider, square and round,
// plus the wait for m_axis_tready.
// r = dot / (n-1) saturates at 1.0; out words carry r squared in Q0.16.
module banded_window_r_squared (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_value
    input  logic        s_axis_tuser,   // [0] start_sequence
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] r_squared, [21:16] lag, zero pad
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import bwr_pkg::*;

    typedef enum logic [2:0] {
        S_RUN, S_FLUSH, S_ROT, S_PREP, S_CHK, S_DIV, S_SQ, S_OUT
    } t_state;

    t_state r_state;
    logic [COUNT_W-1:0]   r_sample_count;
    logic [DEPTH_W-1:0]   r_window_depth;
    logic [POS_W-1:0]     r_pos;
    logic [LAG_W-1:0]     r_held;
    logic [SLOT_W-1:0]    r_head;
    logic [SLOT_W-1:0]    r_rot;
    logic [LAG_W-1:0]     r_lag;
    logic [1:0]           r_flush;
    logic [POS_W-1:0]     r_den;
    logic [ACC_W-1:0]     r_mag;
    logic [POS_W-1:0]     r_rem;
    logic [30:0]          r_bits;
    logic [30:0]          r_q;
    logic [4:0]           r_step;
    logic                 r_sat;
    logic [61:0]          r_sq;

    logic [COUNT_W-1:0]   n_eff;
    logic [LAG_W-1:0]     depth_eff;
    logic [LAG_W-1:0]     held_eff;
    logic [POS_W-1:0]     pos_eff;
    logic [LAG_W-1:0]     partners;
    logic                 in_acc;
    logic                 last_pos;
    logic [POS_W:0]       rem2;
    logic                 ge;
    logic [62:0]          rnd;
    t_cell_cmd            cmd;
    t_cell_ctl            ctl;
    logic signed [ACC_W-1:0] res [SLOT_CNT];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_RUN);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // effective register values
    always_comb begin
        if (r_sample_count < COUNT_W'(2))                n_eff = COUNT_W'(2);
        else if (r_sample_count > COUNT_W'(MAX_SAMPLES)) n_eff = COUNT_W'(MAX_SAMPLES);
        else                                             n_eff = r_sample_count;
        depth_eff = (r_window_depth > DEPTH_W'(SLOT_CNT)) ? LAG_W'(SLOT_CNT)
                                                          : LAG_W'(r_window_depth);
        held_eff  = s_axis_tuser ? '0 : r_held;
        pos_eff   = s_axis_tuser ? '0 : r_pos;
        partners  = (held_eff < depth_eff) ? held_eff : depth_eff;
        last_pos  = ({1'b0, pos_eff} + (POS_W+1)'(1)) >= n_eff;
    end

    // command to the cell row
    always_comb begin
        cmd.valid  = in_acc;
        cmd.clr    = s_axis_tuser;
        cmd.head   = r_head;
        cmd.held   = held_eff;
        cmd.pos    = pos_eff;
        cmd.sample = s_axis_tdata;
        ctl.load   = (r_state == S_FLUSH) && (r_flush == 2'd3);
        ctl.shift  = ((r_state == S_ROT) && (r_rot != '0))
                  || ((r_state == S_OUT) && m_axis_tready);
    end

    genvar gi;
    generate
        for (gi = 0; gi < SLOT_CNT; gi++) begin : g_cell
            bwr_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_slot     (SLOT_W'(gi)),
                .i_cmd      (cmd),
                .i_ctl      (ctl),
                .i_next_res (res[(gi + 1) % SLOT_CNT]),
                .o_res      (res[gi])
            );
        end
    endgenerate

    // divider step and rounding
    always_comb begin
        rem2 = {r_rem, r_bits[30]};
        ge   = rem2 >= {1'b0, r_den};
        rnd  = {1'b0, r_sq} + (63'(1) << 45);
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= COUNT_W'(2);
            r_window_depth <= DEPTH_W'(SLOT_CNT);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data;
                REG_WINDOW_DEPTH: r_window_depth <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and result path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_pos   <= '0;
            r_held  <= '0;
            r_head  <= '0;
            r_flush <= '0;
        end else begin
            unique case (r_state)
                S_RUN: begin
                    if (in_acc) begin
                        if (last_pos) begin
                            r_pos   <= '0;
                            r_head  <= r_head + SLOT_W'(1);
                            r_held  <= (held_eff < LAG_W'(SLOT_CNT))
                                       ? held_eff + LAG_W'(1) : held_eff;
                            r_lag   <= partners;
                            r_rot   <= r_head - partners[SLOT_W-1:0];
                            r_den   <= POS_W'(n_eff - COUNT_W'(1));
                            r_flush <= '0;
                            r_state <= S_FLUSH;
                        end else begin
                            r_pos  <= pos_eff + POS_W'(1);
                            r_held <= held_eff;
                        end
                    end
                end
                S_FLUSH: begin
                    r_flush <= r_flush + 2'd1;
                    if (r_flush == 2'd3) begin
                        r_state <= (r_lag == '0) ? S_RUN : S_ROT;
                    end
                end
                S_ROT: begin
                    if (r_rot == '0) r_state <= S_PREP;
                    else             r_rot   <= r_rot - SLOT_W'(1);
                end
                S_PREP: begin
                    r_mag   <= res[0][ACC_W-1] ? ACC_W'(-res[0]) : ACC_W'(res[0]);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_sat   <= r_mag >= {14'd0, r_den, 22'd0};
                    r_rem   <= r_mag[22+POS_W-1:22];
                    r_bits  <= {r_mag[21:0], 9'd0};
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= ge ? POS_W'(rem2 - {1'b0, r_den}) : rem2[POS_W-1:0];
                    r_q    <= {r_q[29:0], ge};
                    r_bits <= {r_bits[29:0], 1'b0};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd30) r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sq    <= r_q * r_q;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_lag   <= r_lag - LAG_W'(1);
                        r_state <= (r_lag == LAG_W'(1)) ? S_RUN : S_PREP;
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    // rounded, saturated r squared, formed from the registered square
    logic [RESULT_W-1:0] result;
    always_comb begin
        if (r_sat || (rnd[62:46] > 17'd65535)) result = '1;
        else                                   result = rnd[61:46];
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {2'b00, r_lag, result};
    assign m_axis_tlast  = (r_lag == LAG_W'(1));

endmodule

@@ rtl/core/bwr_checker.sv @@
module bwr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // last word of a run always has lag one
    a_last_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[21:16] == 6'd1)
        else $error("last word with lag other than one");

    // lag never zero on a result
    a_lag_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[21:16] != 6'd0)
        else $error("result with zero lag");

    // input is held off while results drain
    a_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken during drain");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind banded_window_r_squared bwr_checker u_bwr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/banded_window_r_squared_tb.sv @@
module banded_window_r_squared_tb;
    import bwr_pkg::*;

    typedef struct {
        logic [RESULT_W-1:0] r2;
        logic [LAG_W-1:0]    lag;
        logic                last;
    } t_rsq_word;

    // Tracks the window, the lag accumulators and the result words they imply.
    class rsq_scoreboard;
        logic [SAMPLE_W-1:0] ring [SLOT_CNT*MAX_SAMPLES];
        longint              dot [SLOT_CNT];
        int                  pos, held, head;
        int                  count_reg, depth_reg;
        t_rsq_word           pending [$];
        int                  errors, words_seen;

        function new();
            foreach (dot[i]) dot[i] = 0;
            pos = 0; held = 0; head = 0;
            count_reg = 2; depth_reg = 32;
            errors = 0; words_seen = 0;
        endfunction

        function void set_reg(logic idx, logic [COUNT_W-1:0] val);
            if (idx == REG_SAMPLE_COUNT) count_reg = val;
            else depth_reg = val[DEPTH_W-1:0];
        endfunction

        function int vec_len();
            if (count_reg < 2) return 2;
            if (count_reg > MAX_SAMPLES) return MAX_SAMPLES;
            return count_reg;
        endfunction

        // r = dot/(n-1) saturated at 1.0, squared, rounded to Q0.16
        function logic [RESULT_W-1:0] r2_of(longint d, int n);
            longint unsigned mag, den, r31, sq;
            mag = (d < 0) ? -d : d;
            den = n - 1;
            if (mag >= (den << 22)) return 16'hFFFF;
            r31 = (mag << 9) / den;
            sq = (r31 * r31 + (64'd1 << 45)) >> 46;
            return (sq > 65535) ? 16'hFFFF : sq[15:0];
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] w, bit st);
            int n, p, slot, partners, dep;
            t_rsq_word e;
            n = vec_len();
            if (st) begin
                foreach (dot[i]) dot[i] = 0;
                pos = 0; held = 0;
            end
            p = (pos >= MAX_SAMPLES) ? MAX_SAMPLES - 1 : pos;
            for (int lag = 1; lag <= held; lag++) begin
                slot = (head + SLOT_CNT - lag) % SLOT_CNT;
                dot[lag-1] += longint'($signed(w))
                            * longint'($signed(ring[slot*MAX_SAMPLES + p]));
            end
            ring[head*MAX_SAMPLES + p] = w;
            if (p + 1 < n) begin
                pos = p + 1;
                return;
            end
            dep = (depth_reg > SLOT_CNT) ? SLOT_CNT : depth_reg;
            partners = (held < dep) ? held : dep;
            for (int lag = partners; lag >= 1; lag--) begin
                e.r2 = r2_of(dot[lag-1], n);
                e.lag = LAG_W'(lag);
                e.last = (lag == 1);
                pending.insert(pending.size(), e);
            end
            foreach (dot[i]) dot[i] = 0;
            pos = 0;
            head = (head + 1) % SLOT_CNT;
            if (held < SLOT_CNT) held++;
        endfunction

        function void check_word(logic [23:0] d, logic last);
            t_rsq_word e;
            words_seen++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 20)
                    $display("%0t unexpected word r2=%h lag=%0d last=%b",
                             $time, d[15:0], d[21:16], last);
                return;
            end
            e = pending.pop_front();
            if (d[15:0] !== e.r2 || d[21:16] !== e.lag || last !== e.last) begin
                errors++;
                if (errors <= 20)
                    $display({"%0t mismatch: expected r2=%h lag=%0d last=%b, ",
                              "got r2=%h lag=%0d last=%b"},
                             $time, e.r2, e.lag, e.last, d[15:0], d[21:16], last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] sample_value
    logic        s_axis_tuser;   // [0] start_sequence
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [15:0] r_squared, [21:16] lag, zero pad
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [12:0] i_cfg_data;

    banded_window_r_squared i_dut (.*);

    rsq_scoreboard sb = new();
    bit  hold_req = 0;
    int  burst_left = 0;
    int  samples_sent = 0;
    int  phases_run = 0;
    int  idle_cycles = 0;
    int  prev_vec [MAX_SAMPLES];

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast);
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 6000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall pattern, with an occasional long hold-off
    initial begin
        int len;
        m_axis_tready <= 1'b0;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b1;
                repeat (60) @(posedge i_clk);
            end else begin
                len = $urandom_range(1, 12);
                m_axis_tready <= 1'b1;
                repeat (len) @(posedge i_clk);
                len = $urandom_range(1, 5);
                m_axis_tready <= 1'b0;
                repeat (len) @(posedge i_clk);
            end
        end
    end

    task automatic send_word(input logic [15:0] w, input bit st);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= st;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(w, st);
        samples_sent++;
    endtask

    // stop sending, wait for every expected word, then let the block settle
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [12:0] cnt, input logic [12:0] dep);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_SAMPLE_COUNT;
        i_cfg_data  <= cnt;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(REG_SAMPLE_COUNT, cnt);
        i_cfg_index <= REG_WINDOW_DEPTH;
        i_cfg_data  <= dep;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(REG_WINDOW_DEPTH, dep);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample(int p);
        int v;
        case ($urandom_range(0, 4))
            0: v = $urandom();
            1, 2: v = prev_vec[p] + $urandom_range(0, 255) - 128;
            default: v = $urandom_range(0, 4095) - 2048;
        endcase
        return v[15:0];
    endfunction

    // one configuration, a fresh sequence of nvec vectors
    task automatic run_phase(input logic [12:0] cnt, input logic [12:0] dep,
                             input int nvec, input bit noisy, input int hold_at);
        int n;
        logic [15:0] w;
        write_regs(cnt, dep);
        n = sb.vec_len();
        for (int v = 0; v < nvec; v++) begin
            if (v == hold_at) hold_req = 1;
            for (int p = 0; p < n; p++) begin
                w = pick_sample(p);
                prev_vec[p] = $signed(w);
                send_word(w, (v == 0 && p == 0) || (noisy && $urandom_range(0, 39) == 0));
            end
        end
        drain_all();
        phases_run++;
    endtask

    initial begin
        logic [12:0] cnt;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_SAMPLE_COUNT;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        foreach (prev_vec[i]) prev_vec[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero count acts as two, zero depth gives no words
        write_regs(13'd0, 13'd0);
        send_word(16'h7FFF, 1'b1); send_word(16'h8000, 1'b0);
        send_word(16'h8000, 1'b0); send_word(16'h8000, 1'b0);
        drain_all();

        // depth above max, count one: saturation, zero, negative, tiny, restarts
        write_regs(13'd1, 13'd63);
        send_word(16'h8000, 1'b1); send_word(16'h8000, 1'b0);
        send_word(16'h8000, 1'b0); send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0); send_word(16'h7FFF, 1'b0);
        send_word(16'h0000, 1'b0); send_word(16'h0000, 1'b0);
        send_word(16'h7FFF, 1'b0); send_word(16'h8000, 1'b0);
        send_word(16'h0001, 1'b0); send_word(16'h0001, 1'b0);
        send_word(16'h0123, 1'b1); send_word(16'h0045, 1'b1);
        send_word(16'h0067, 1'b0); send_word(16'hFF00, 1'b0);
        send_word(16'h0100, 1'b0);
        drain_all();

        // random sequences on small vectors; full window and pressure in the second
        for (int ph = 0; ph < 6; ph++) begin
            cnt = 13'($urandom_range(2, 5));
            case (ph)
                1: run_phase(13'd2, 13'd32, 36, 1'b0, 33);
                2: run_phase(cnt, 13'd1, 6, 1'b1, -1);
                default: run_phase(cnt, 13'($urandom_range(0, 63)),
                                   $urandom_range(3, 6), 1'b1, -1);
            endcase
        end

        $display("Sent %0d samples over %0d phases, checked %0d result words,",
                 samples_sent, phases_run + 2, sb.words_seen);
        $display("covering low count and high depth clamps, saturation, restarts, a full");
        $display("window and stall pressure.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
